// ===== src/mps_pkg.sv =====
// mps_pkg: shared types and constants for the markup phrase splitter.
// No dependencies.
`timescale 1ns / 1ps

package mps_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;
    localparam logic [BYTE_W-1:0]  MIN_LEN_RESET = 8'd10;

    localparam logic [BYTE_W-1:0] CH_LT     = 8'h3C;  // '<'
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3E;  // '>'
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;  // '.'
    localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;  // '?'
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;  // ':'
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;  // ')'
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;  // ' '
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [BYTE_W-1:0] PRINT_LO  = 8'h21;
    localparam logic [BYTE_W-1:0] PRINT_HI  = 8'h7E;

    typedef struct packed {
        logic               inside_tag;
        logic               after_space;
        logic               at_phrase_start;
        logic               last_was_digit;
        logic [COUNT_W-1:0] phrase_count;
    } mps_state_t;

    localparam mps_state_t STATE_RESET = '{
        inside_tag:      1'b0,
        after_space:     1'b0,
        at_phrase_start: 1'b1,
        last_was_digit:  1'b0,
        phrase_count:    '0
    };

    typedef struct packed {
        logic [BYTE_W-1:0] char_out;
        logic              char_valid;
        logic              phrase_end;
        logic              phrase_keep;
        logic              phrase_discard;
    } mps_result_t;

endpackage

// ===== src/mps_step.sv =====
// mps_step: combinational per-byte update of the splitter state and result.
// Depends on mps_pkg.
`timescale 1ns / 1ps

module mps_step
(
    input  mps_pkg::mps_state_t                 state_cur,
    input  logic [mps_pkg::BYTE_W-1:0]          byte_in,
    input  logic                                end_of_file,
    input  logic [mps_pkg::BYTE_W-1:0]          min_len,
    output mps_pkg::mps_state_t                 state_nxt,
    output mps_pkg::mps_result_t                result,
    output logic                                emit
);

    function automatic logic [mps_pkg::COUNT_W-1:0] sat_inc(
        input logic [mps_pkg::COUNT_W-1:0] cnt
    );
        if (cnt < mps_pkg::COUNT_MAX)
        begin
            return cnt + mps_pkg::COUNT_W'(1);
        end
        return cnt;
    endfunction

    logic                          printable;
    logic                          is_digit;
    logic                          is_term;
    logic                          sep_append;
    logic [mps_pkg::COUNT_W-1:0]   count_inc;
    mps_pkg::mps_state_t           st;
    mps_pkg::mps_result_t          r;

    assign printable  = (byte_in >= mps_pkg::PRINT_LO) && (byte_in <= mps_pkg::PRINT_HI);
    assign is_digit   = (byte_in >= mps_pkg::CH_ZERO) && (byte_in <= mps_pkg::CH_NINE);
    assign is_term    = ((byte_in == mps_pkg::CH_DOT) && !state_cur.last_was_digit)
                        || (byte_in == mps_pkg::CH_QUEST)
                        || (byte_in == mps_pkg::CH_COLON)
                        || (byte_in == mps_pkg::CH_RPAREN);
    assign sep_append = !state_cur.after_space && !state_cur.at_phrase_start;
    assign count_inc  = sat_inc(state_cur.phrase_count);

    always_comb
    begin
        st = state_cur;
        r  = '0;
        priority if (state_cur.inside_tag)
        begin
            if (byte_in == mps_pkg::CH_GT)
            begin
                st.inside_tag  = 1'b0;
                st.after_space = 1'b1;
                if (sep_append)
                begin
                    st.phrase_count = count_inc;
                    r.char_valid    = 1'b1;
                    r.char_out      = mps_pkg::CH_SPACE;
                end
            end
        end
        else if (byte_in == mps_pkg::CH_LT)
        begin
            st.inside_tag = 1'b1;
        end
        else if (printable)
        begin
            st.after_space    = 1'b0;
            st.last_was_digit = is_digit;
            r.char_valid      = 1'b1;
            r.char_out        = byte_in;
            if (is_term)
            begin
                r.phrase_end       = 1'b1;
                r.phrase_keep      = count_inc > {1'b0, min_len};
                st.phrase_count    = '0;
                st.at_phrase_start = 1'b1;
            end
            else
            begin
                st.phrase_count    = count_inc;
                st.at_phrase_start = 1'b0;
            end
        end
        else
        begin
            st.after_space = 1'b1;
            if (sep_append)
            begin
                st.phrase_count = count_inc;
                r.char_valid    = 1'b1;
                r.char_out      = mps_pkg::CH_SPACE;
            end
        end

        if (end_of_file)
        begin
            r.phrase_discard = st.phrase_count != '0;
            st               = mps_pkg::STATE_RESET;
        end
    end

    assign state_nxt = st;
    assign result    = r;
    assign emit      = r.char_valid || r.phrase_discard;

endmodule

// ===== src/markup_phrase_splitter_unit.sv =====
// Pipeline: byte transfer into the input register, then into the result register.
// Throughput: one byte per cycle while the result side is ready.
// Bytes that produce no result retire without occupying the result register.
// Reset (rst_n low, async): pipeline empty, splitter state cleared,
// min_phrase_length back to 10.
// markup_phrase_splitter_unit: top level; depends on mps_pkg and mps_step.
`timescale 1ns / 1ps

module markup_phrase_splitter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mps_pkg::BYTE_W-1:0]    cfg_data,

    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [mps_pkg::BYTE_W-1:0]    byte_in,
    input  logic                          end_of_file,

    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [mps_pkg::BYTE_W-1:0]    char_out,
    output logic                          char_valid,
    output logic                          phrase_end,
    output logic                          phrase_keep,
    output logic                          phrase_discard
);

    logic [mps_pkg::BYTE_W-1:0] min_len_reg;

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    logic [mps_pkg::BYTE_W-1:0] s1_byte_reg;
    logic                       s1_eof_reg;

    mps_pkg::mps_state_t        st_reg;
    mps_pkg::mps_state_t        st_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    mps_pkg::mps_result_t       out_reg;
    mps_pkg::mps_result_t       step_result;
    logic                       step_emit;

    logic                       out_free;
    logic                       s1_fire;
    logic                       in_xfer;

    assign cfg_ready  = 1'b1;
    assign out_free   = !out_valid_reg || result_ready;
    assign s1_fire    = s1_valid_reg && out_free;
    assign item_ready = !s1_valid_reg || out_free;
    assign in_xfer    = item_valid && item_ready;

    mps_step u_step
    (
        .state_cur   (st_reg),
        .byte_in     (s1_byte_reg),
        .end_of_file (s1_eof_reg),
        .min_len     (min_len_reg),
        .state_nxt   (st_next),
        .result      (step_result),
        .emit        (step_emit)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire && step_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg   <= mps_pkg::MIN_LEN_RESET;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= mps_pkg::STATE_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_len_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                st_reg <= st_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= byte_in;
            s1_eof_reg  <= end_of_file;
        end
        if (s1_fire && step_emit)
        begin
            out_reg <= step_result;
        end
    end

    assign result_valid   = out_valid_reg;
    assign char_out       = out_reg.char_out;
    assign char_valid     = out_reg.char_valid;
    assign phrase_end     = out_reg.phrase_end;
    assign phrase_keep    = out_reg.phrase_keep;
    assign phrase_discard = out_reg.phrase_discard;

    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input stage lost a byte while stalled");

    a_empty_is_discard: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !char_valid) |-> phrase_discard)
        else $error("result with no character and no discard");

    a_end_has_char: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && phrase_end) |-> char_valid)
        else $error("phrase end without character");

    a_keep_needs_end: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && phrase_keep) |-> phrase_end)
        else $error("keep flag outside phrase end");

    a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_eof_reg) |=>
            (st_reg.phrase_count == '0 && st_reg.at_phrase_start && !st_reg.inside_tag))
        else $error("state not cleared after end of file");

endmodule
